// ----- rtl/core/tgq_pkg.sv -----
package tgq_pkg;

    localparam int ELEMENTS_DEF = 1024;
    localparam int TEAMS_DEF    = 32;
    localparam int CAPACITY_DEF = 256;

    localparam int ELEM_W   = 10;
    localparam int TEAM_W   = 5;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    typedef enum logic [KIND_W-1:0] {
        K_ASSIGN  = 2'd0,
        K_ENQUEUE = 2'd1,
        K_DEQUEUE = 2'd2,
        K_CLEAR   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_EMPTY      = 2'd1,
        ST_UNASSIGNED = 2'd2,
        ST_FULL       = 2'd3
    } status_t;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SWEEP    = 8'b0000_0010,
        S_ENQ_CHK  = 8'b0000_0100,
        S_ENQ_WR   = 8'b0000_1000,
        S_DEQ_TEAM = 8'b0001_0000,
        S_DEQ_SLOT = 8'b0010_0000,
        S_DEQ_WR   = 8'b0100_0000,
        S_HOLD     = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic [ELEM_W-1:0] element;
        logic              has;
        status_t           status;
    } result_t;

endpackage

// ----- rtl/core/team_grouped_queue_top.sv -----
// assign and empty dequeue answer from idle; enqueue reads membership, then free link and
// team tail; dequeue reads order, then team head and tail, then slot value and link, each a
// registered memory read; s_tready is high only in idle, so no new item is taken before the
// last result is in the output register; clear: a sweep rewrites membership and slot links
// reset: synchronous active-low aresetn; after release the same sweep runs with no
// transfer out, and s_tready stays low until it ends
module team_grouped_queue_top
    import tgq_pkg::*;
#(
    parameter int ELEMENTS = ELEMENTS_DEF,
    parameter int TEAMS    = TEAMS_DEF,
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // element_id [9:0], team_id [14:10], zero fill
    input  logic [1:0]  s_tuser,   // kind [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_element [9:0], status [11:10], zero fill
    output logic        m_tuser    // has_element [0]
);

    localparam int EAW   = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
    localparam int TAW   = (TEAMS > 1) ? $clog2(TEAMS) : 1;
    localparam int TCW   = $clog2(TEAMS + 1);
    localparam int CAW   = $clog2(CAPACITY);
    localparam int CNTW  = $clog2(CAPACITY + 1);
    localparam int OCW   = $clog2(TEAMS + 1);
    localparam int SWEEP = (ELEMENTS > CAPACITY) ? ELEMENTS : CAPACITY;
    localparam int SWW   = $clog2(SWEEP);

    // memories: membership, slot value, slot link, team head, team tail, team order
    logic [TCW-1:0]    mt_mem [ELEMENTS];
    logic [ELEM_W-1:0] sv_mem [CAPACITY];
    logic [CAW-1:0]    sl_mem [CAPACITY];
    logic [CAW-1:0]    th_mem [TEAMS];
    logic [CAW-1:0]    tt_mem [TEAMS];
    logic [TAW-1:0]    to_mem [TEAMS];

    logic              mt_we, sv_we, sl_we, th_we, tt_we, to_we;
    logic [EAW-1:0]    mt_wa, mt_ra;
    logic [TCW-1:0]    mt_wd, mt_rd;
    logic [CAW-1:0]    sv_wa, sv_ra, sl_wa, sl_ra, sl_wd, sl_rd;
    logic [ELEM_W-1:0] sv_wd, sv_rd;
    logic [TAW-1:0]    th_wa, th_ra, tt_wa, tt_ra, to_wa, to_ra, to_wd, to_rd;
    logic [CAW-1:0]    th_wd, th_rd, tt_wd, tt_rd;

    always_ff @(posedge aclk) begin
        if (mt_we) mt_mem[mt_wa] <= mt_wd;
        mt_rd <= mt_mem[mt_ra];
    end
    always_ff @(posedge aclk) begin
        if (sv_we) sv_mem[sv_wa] <= sv_wd;
        sv_rd <= sv_mem[sv_ra];
    end
    always_ff @(posedge aclk) begin
        if (sl_we) sl_mem[sl_wa] <= sl_wd;
        sl_rd <= sl_mem[sl_ra];
    end
    always_ff @(posedge aclk) begin
        if (th_we) th_mem[th_wa] <= th_wd;
        th_rd <= th_mem[th_ra];
    end
    always_ff @(posedge aclk) begin
        if (tt_we) tt_mem[tt_wa] <= tt_wd;
        tt_rd <= tt_mem[tt_ra];
    end
    always_ff @(posedge aclk) begin
        if (to_we) to_mem[to_wa] <= to_wd;
        to_rd <= to_mem[to_ra];
    end

    // control state
    state_t            state_reg, state_next;
    logic [SWW-1:0]    sweep_reg, sweep_next;
    logic              respond_reg, respond_next;   // clear sweep owes a transfer
    logic [CAW-1:0]    free_head_reg, free_head_next;
    logic [TAW-1:0]    front_reg, front_next, back_reg, back_next;
    logic [OCW-1:0]    order_count_reg, order_count_next;
    logic [CNTW-1:0]   total_reg, total_next;
    logic [TEAMS-1:0]  present_reg, present_next;
    logic              m_valid_reg, m_valid_next;

    // payload
    logic [ELEM_W-1:0] elem_reg, elem_next;
    logic [TAW-1:0]    team_reg, team_next;
    logic [CAW-1:0]    slot_reg, slot_next;
    logic              last_reg, last_next;
    result_t           hold_reg, hold_next, m_res_reg, m_res_next;

    // input fields
    kind_t             in_kind;
    logic [ELEM_W-1:0] in_elem;
    logic [TEAM_W-1:0] in_team;
    logic              in_xfer, out_free, done;
    result_t           res;

    assign in_kind  = kind_t'(s_tuser);
    assign in_elem  = s_tdata[ELEM_W-1:0];
    assign in_team  = s_tdata[ELEM_W+TEAM_W-1:ELEM_W];
    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, m_res_reg.status, m_res_reg.element};
    assign m_tuser  = m_res_reg.has;

    always_comb begin
        state_next       = state_reg;
        sweep_next       = sweep_reg;
        respond_next     = respond_reg;
        free_head_next   = free_head_reg;
        front_next       = front_reg;
        back_next        = back_reg;
        order_count_next = order_count_reg;
        total_next       = total_reg;
        present_next     = present_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_res_next       = m_res_reg;
        hold_next        = hold_reg;
        elem_next        = elem_reg;
        team_next        = team_reg;
        slot_next        = slot_reg;
        last_next        = last_reg;
        done             = 1'b0;
        res              = '{element: '0, has: 1'b0, status: ST_OK};

        mt_we = 1'b0; mt_wa = '0; mt_wd = '0; mt_ra = '0;
        sv_we = 1'b0; sv_wa = '0; sv_wd = '0; sv_ra = '0;
        sl_we = 1'b0; sl_wa = '0; sl_wd = '0; sl_ra = '0;
        th_we = 1'b0; th_wa = '0; th_wd = '0; th_ra = '0;
        tt_we = 1'b0; tt_wa = '0; tt_wd = '0; tt_ra = '0;
        to_we = 1'b0; to_wa = '0; to_wd = '0; to_ra = '0;

        case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    elem_next = in_elem;
                    case (in_kind)
                        K_ASSIGN: begin
                            done = 1'b1;
                            if (32'(in_elem) >= ELEMENTS) begin
                                res.status = ST_UNASSIGNED;
                            end else begin
                                mt_we = 1'b1;
                                mt_wa = EAW'(in_elem);
                                if (32'(in_team) >= TEAMS) begin
                                    mt_wd      = TCW'(TEAMS);
                                    res.status = ST_UNASSIGNED;
                                end else begin
                                    mt_wd = TCW'(in_team);
                                end
                            end
                        end
                        K_ENQUEUE: begin
                            if (32'(in_elem) >= ELEMENTS) begin
                                done       = 1'b1;
                                res.status = ST_UNASSIGNED;
                            end else begin
                                mt_ra      = EAW'(in_elem);
                                state_next = S_ENQ_CHK;
                            end
                        end
                        K_DEQUEUE: begin
                            if (total_reg == '0 || order_count_reg == '0) begin
                                done       = 1'b1;
                                res.status = ST_EMPTY;
                            end else begin
                                to_ra      = front_reg;
                                state_next = S_DEQ_TEAM;
                            end
                        end
                        default: begin
                            sweep_next   = '0;
                            respond_next = 1'b1;
                            state_next   = S_SWEEP;
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                // unassign every element, relink every slot to the next one, the last back to slot 0
                if (32'(sweep_reg) < ELEMENTS) begin
                    mt_we = 1'b1;
                    mt_wa = EAW'(sweep_reg);
                    mt_wd = TCW'(TEAMS);
                end
                if (32'(sweep_reg) < CAPACITY) begin
                    sl_we = 1'b1;
                    sl_wa = CAW'(sweep_reg);
                    sl_wd = (32'(sweep_reg) == CAPACITY - 1) ? '0 : CAW'(sweep_reg + 1'b1);
                end
                sweep_next = sweep_reg + 1'b1;
                if (32'(sweep_reg) == SWEEP - 1) begin
                    free_head_next   = '0;
                    front_next       = '0;
                    back_next        = '0;
                    order_count_next = '0;
                    total_next       = '0;
                    present_next     = '0;
                    respond_next     = 1'b0;
                    if (respond_reg) done = 1'b1;
                    else             state_next = S_IDLE;
                end
            end
            S_ENQ_CHK: begin
                if (32'(mt_rd) >= TEAMS) begin
                    done       = 1'b1;
                    res.status = ST_UNASSIGNED;
                end else if (32'(total_reg) >= CAPACITY) begin
                    done       = 1'b1;
                    res.status = ST_FULL;
                end else begin
                    team_next  = TAW'(mt_rd);
                    sl_ra      = free_head_reg;
                    tt_ra      = TAW'(mt_rd);
                    state_next = S_ENQ_WR;
                end
            end
            S_ENQ_WR: begin
                free_head_next = sl_rd;
                sv_we = 1'b1;
                sv_wa = free_head_reg;
                sv_wd = elem_reg;
                tt_we = 1'b1;
                tt_wa = team_reg;
                tt_wd = free_head_reg;
                if (present_reg[team_reg]) begin
                    // append behind the team's last queued member
                    sl_we = 1'b1;
                    sl_wa = tt_rd;
                    sl_wd = free_head_reg;
                end else begin
                    // team joins at the back of the order queue
                    th_we = 1'b1;
                    th_wa = team_reg;
                    th_wd = free_head_reg;
                    to_we = 1'b1;
                    to_wa = back_reg;
                    to_wd = team_reg;
                    present_next[team_reg] = 1'b1;
                    back_next = (32'(back_reg) == TEAMS - 1) ? '0 : back_reg + 1'b1;
                    order_count_next = order_count_reg + 1'b1;
                end
                total_next = total_reg + 1'b1;
                done       = 1'b1;
            end
            S_DEQ_TEAM: begin
                team_next  = to_rd;
                th_ra      = to_rd;
                tt_ra      = to_rd;
                state_next = S_DEQ_SLOT;
            end
            S_DEQ_SLOT: begin
                slot_next  = th_rd;
                last_next  = (th_rd == tt_rd);
                sv_ra      = th_rd;
                sl_ra      = th_rd;
                state_next = S_DEQ_WR;
            end
            S_DEQ_WR: begin
                if (last_reg) begin
                    present_next[team_reg] = 1'b0;
                    front_next = (32'(front_reg) == TEAMS - 1) ? '0 : front_reg + 1'b1;
                    order_count_next = order_count_reg - 1'b1;
                end else begin
                    th_we = 1'b1;
                    th_wa = team_reg;
                    th_wd = sl_rd;
                end
                // freed slot goes to the front of the free list
                sl_we = 1'b1;
                sl_wa = slot_reg;
                sl_wd = free_head_reg;
                free_head_next = slot_reg;
                total_next     = total_reg - 1'b1;
                res.element    = sv_rd;
                res.has        = 1'b1;
                done           = 1'b1;
            end
            S_HOLD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_res_next   = hold_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (done) begin
            if (out_free) begin
                m_valid_next = 1'b1;
                m_res_next   = res;
                state_next   = S_IDLE;
            end else begin
                hold_next  = res;
                state_next = S_HOLD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_SWEEP;
            sweep_reg       <= '0;
            respond_reg     <= 1'b0;
            free_head_reg   <= '0;
            front_reg       <= '0;
            back_reg        <= '0;
            order_count_reg <= '0;
            total_reg       <= '0;
            present_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            sweep_reg       <= sweep_next;
            respond_reg     <= respond_next;
            free_head_reg   <= free_head_next;
            front_reg       <= front_next;
            back_reg        <= back_next;
            order_count_reg <= order_count_next;
            total_reg       <= total_next;
            present_reg     <= present_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        elem_reg  <= elem_next;
        team_reg  <= team_next;
        slot_reg  <= slot_next;
        last_reg  <= last_next;
        hold_reg  <= hold_next;
        m_res_reg <= m_res_next;
    end

    // checks
    a_total_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(total_reg) <= CAPACITY)
        else $error("queued count above capacity");

    a_order_le_total: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(order_count_reg) <= 32'(total_reg))
        else $error("more queued teams than queued elements");

    a_present_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(present_reg) == 32'(order_count_reg))
        else $error("present flags disagree with order count");

    a_clear_sweeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && in_kind == K_CLEAR) |=> (state_reg == S_SWEEP && sweep_reg == '0))
        else $error("clear did not start a sweep");

endmodule

// ----- sim/tb.sv -----
module tb;
    import tgq_pkg::*;

    localparam int NELEM = 1024;
    localparam int NTEAM = 32;
    localparam int NCAP  = 256;
    localparam int STALL_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // element_id [9:0], team_id [14:10], zero fill
    logic [1:0]  s_tuser = '0;   // kind [1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // out_element [9:0], status [11:10], zero fill
    logic        m_tuser;        // has_element [0]

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    team_grouped_queue_top uut (.*);

    // shadow of the queue: team per element, and one element list per team
    logic [5:0]        team_of [NELEM];
    logic [ELEM_W-1:0] team_list [NTEAM][$];
    logic [4:0]        team_seq [$];
    int                queued;
    result_t           pending [$];

    int  errors = 0;
    int  sent = 0;
    int  got = 0;
    int  idle_cnt = 0;
    bit  calm = 1'b0;

    // reset / clear image of the shadow
    function automatic void wipe_shadow();
        foreach (team_of[i]) team_of[i] = 6'(NTEAM);
        foreach (team_list[t]) team_list[t].delete();
        team_seq.delete();
        queued = 0;
    endfunction

    // behavior of one item in terms of teams
    function automatic result_t queue_step(kind_t k, logic [9:0] el, logic [4:0] tm);
        result_t r;
        logic [4:0] t;
        r = '{element: '0, has: 1'b0, status: ST_OK};
        case (k)
            K_ASSIGN: team_of[el] = {1'b0, tm};
            K_ENQUEUE: begin
                if (team_of[el] >= NTEAM) r.status = ST_UNASSIGNED;
                else if (queued >= NCAP) r.status = ST_FULL;
                else begin
                    t = team_of[el][4:0];
                    if (team_list[t].size() == 0) team_seq.push_back(t);
                    team_list[t].push_back(el);
                    queued++;
                end
            end
            K_DEQUEUE: begin
                if (queued == 0) r.status = ST_EMPTY;
                else begin
                    t = team_seq[0];
                    r.element = team_list[t].pop_front();
                    r.has = 1'b1;
                    if (team_list[t].size() == 0) void'(team_seq.pop_front());
                    queued--;
                end
            end
            default: wipe_shadow();
        endcase
        return r;
    endfunction

    // one transfer into the block, with random idling ahead of it
    task automatic send_item(kind_t k, logic [9:0] el, logic [4:0] tm);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, tm, el};
        s_tuser  <= k;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending.push_back(queue_step(k, el, tm));
        sent++;
        @(negedge aclk);
    endtask

    // receiver with random stall bursts
    initial begin
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // checker for each result transfer
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got++;
            if (pending.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                want = pending.pop_front();
                if (m_tdata[9:0] !== want.element) begin
                    $error("out_element expected %0d got %0d", want.element, m_tdata[9:0]);
                    errors++;
                end
                if (m_tuser !== want.has) begin
                    $error("has_element expected %0d got %0d", want.has, m_tuser);
                    errors++;
                end
                if (m_tdata[11:10] !== want.status) begin
                    $error("status expected %0d got %0d", want.status, m_tdata[11:10]);
                    errors++;
                end
                if (m_tdata[15:12] !== 4'd0) begin
                    $error("zero fill expected 0 got %0h", m_tdata[15:12]);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // extremes and special cases: empty queue, unassigned element, duplicates, reassignment, clear
    task automatic test_directed();
        send_item(K_DEQUEUE, 10'd0, 5'd0);        // empty queue
        send_item(K_ENQUEUE, 10'd1023, 5'd31);    // unassigned element
        send_item(K_ASSIGN, 10'd1023, 5'd31);
        send_item(K_ASSIGN, 10'd0, 5'd0);
        send_item(K_ASSIGN, 10'd5, 5'd0);
        send_item(K_ASSIGN, 10'd682, 5'd21);
        send_item(K_ENQUEUE, 10'd1023, 5'd0);
        send_item(K_ENQUEUE, 10'd0, 5'd31);
        send_item(K_ENQUEUE, 10'd682, 5'd10);
        send_item(K_ENQUEUE, 10'd5, 5'd0);        // joins team 0 ahead of 21
        send_item(K_ENQUEUE, 10'd5, 5'd0);        // duplicate copy
        send_item(K_ASSIGN, 10'd5, 5'd21);        // reassign, queued copies stay
        send_item(K_ENQUEUE, 10'd5, 5'd0);
        repeat (7) send_item(K_DEQUEUE, 10'd341, 5'd0);
        send_item(K_CLEAR, 10'd1023, 5'd31);
        send_item(K_ENQUEUE, 10'd0, 5'd0);        // cleared membership
        send_item(K_DEQUEUE, 10'd0, 5'd0);
        wait_drained();
    endtask

    // fill to capacity, hit the full status, then drain past empty
    task automatic test_full_queue();
        int i;
        for (i = 0; i < 8; i++) send_item(K_ASSIGN, 10'(i), 5'(i * 4));
        for (i = 0; i < NCAP + 3; i++) send_item(K_ENQUEUE, 10'($urandom_range(0, 7)), 5'd0);
        for (i = 0; i < NCAP + 2; i++) send_item(K_DEQUEUE, 10'($urandom), 5'($urandom));
        wait_drained();
    endtask

    // mostly well-formed traffic on a small element pool, some noise
    task automatic test_random(int n);
        int i, r;
        logic [9:0] el;
        for (i = 0; i < n; i++) begin
            if (i > n - 150) calm = 1'b1;
            r = $urandom_range(0, 99);
            el = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 47));
            if (r < 20) send_item(K_ASSIGN, el, 5'($urandom));
            else if (r < 62) send_item(K_ENQUEUE, el, 5'($urandom));
            else if (r < 99) send_item(K_DEQUEUE, 10'($urandom), 5'($urandom));
            else send_item(K_CLEAR, 10'($urandom), 5'($urandom));
        end
        wait_drained();
    endtask

    initial begin
        wipe_shadow();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_full_queue();
        test_random(1200);
        repeat (20) @(posedge aclk);
        $display("covered %0d items and %0d results: membership, team grouping,", sent, got);
        $display("duplicates, reassignment, full and empty queue, clear, random stalls");
        if (errors == 0 && pending.size() == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule
